[src/tvfs_pkg.sv]
`default_nettype none
package tvfs_pkg;

  localparam logic [3:0] KIND_F32 = 4'd0;
  localparam logic [3:0] KIND_F64 = 4'd1;
  localparam logic [3:0] KIND_S8  = 4'd2;
  localparam logic [3:0] KIND_U8  = 4'd3;
  localparam logic [3:0] KIND_S16 = 4'd4;
  localparam logic [3:0] KIND_U16 = 4'd5;
  localparam logic [3:0] KIND_S32 = 4'd6;
  localparam logic [3:0] KIND_U32 = 4'd7;
  localparam logic [3:0] KIND_S64 = 4'd8;
  localparam logic [3:0] KIND_U64 = 4'd9;

  localparam logic [2:0] MODE_EXACT = 3'd0;
  localparam logic [2:0] MODE_RANGE = 3'd1;

  localparam logic [3:0] REG_VALUE_KIND      = 4'd0;
  localparam logic [3:0] REG_ALLOW_UNALIGNED = 4'd1;
  localparam logic [3:0] REG_MATCH_MODE      = 4'd2;
  localparam logic [3:0] REG_TARGET_LOW      = 4'd3;
  localparam logic [3:0] REG_TARGET_HIGH     = 4'd4;
  localparam logic [3:0] REG_TOLERANCE       = 4'd5;
  localparam logic [3:0] REG_BASE_ADDRESS    = 4'd6;
  localparam logic [3:0] REG_HIT_LIMIT       = 4'd7;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] hit_address;
    logic [63:0] hit_value_bits;
    logic        final_res;
    logic [30:0] hit_total;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  value_kind;
    logic        allow_unaligned;
    logic [2:0]  match_mode;
    logic [63:0] target_low_bits;
    logic [63:0] target_high_bits;
    logic [63:0] tolerance_bits;
    logic [63:0] base_address;
    logic [30:0] hit_limit;
  } cfg_t;

  typedef struct packed {
    logic        cand;
    logic [63:0] raw;
    logic [63:0] start;
    logic        last;
  } entry_t;

  typedef struct packed {
    logic        cand;
    logic [63:0] v;
    logic [63:0] start;
    logic        last;
  } val_t;

  function automatic logic [6:0] clz64(input logic [63:0] x);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) n = 7'(63 - i);
    end
    return n;
  endfunction

  function automatic logic is_nan(input logic [63:0] x);
    return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
  endfunction

  // IEEE a <= b, false on NaN
  function automatic logic fle(input logic [63:0] a, input logic [63:0] b);
    logic r;
    if (is_nan(a) || is_nan(b)) r = 1'b0;
    else if (a[62:0] == 63'd0 && b[62:0] == 63'd0) r = 1'b1;
    else if (a[63] != b[63]) r = a[63];
    else if (!a[63]) r = (a[62:0] <= b[62:0]);
    else r = (a[62:0] >= b[62:0]);
    return r;
  endfunction

endpackage
`default_nettype wire

[src/typed_value_first_scan.sv]
// Typed value scan over a byte stream. Bytes enter on the in channel at one item per
// clock while the queue has room; each byte that completes an element of the configured
// type (aligned unless unaligned is allowed) is converted to an IEEE double and compared
// against the target (exact within tolerance, or an inclusive range). A result item
// leaves for every match below the hit limit and for the last byte of the buffer.
// Throughput is one byte per cycle unless the output stalls; the three conversion stages
// and five double subtract and compare stages follow a four-entry queue. The user must
// write registers through the cfg channel only while no scan is busy; the block does not enforce it.
`default_nettype none
module typed_value_first_scan import tvfs_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_item,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  cfg_t   cfg;
  logic   q_full, q_push, q_not_empty, en;
  entry_t q_in, q_head;
  logic   cv_vld;
  val_t   cv_val;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.value_kind       <= KIND_S32;
      cfg.allow_unaligned  <= 1'b0;
      cfg.match_mode       <= MODE_EXACT;
      cfg.target_low_bits  <= '0;
      cfg.target_high_bits <= '0;
      cfg.tolerance_bits   <= '0;
      cfg.base_address     <= '0;
      cfg.hit_limit        <= 31'd1024;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_VALUE_KIND:      cfg.value_kind       <= cfg_data[3:0];
        REG_ALLOW_UNALIGNED: cfg.allow_unaligned  <= cfg_data[0];
        REG_MATCH_MODE:      cfg.match_mode       <= cfg_data[2:0];
        REG_TARGET_LOW:      cfg.target_low_bits  <= cfg_data;
        REG_TARGET_HIGH:     cfg.target_high_bits <= cfg_data;
        REG_TOLERANCE:       cfg.tolerance_bits   <= cfg_data;
        REG_BASE_ADDRESS:    cfg.base_address     <= cfg_data;
        REG_HIT_LIMIT:       cfg.hit_limit        <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  tvfs_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .in_item, .cfg,
    .q_full(q_full), .push(q_push), .entry(q_in)
  );

  tvfs_queue u_queue (
    .clk, .rst, .push(q_push), .push_entry(q_in), .full(q_full),
    .pop(en), .not_empty(q_not_empty), .head(q_head)
  );

  tvfs_convert u_convert (
    .clk, .rst, .en, .in_vld(q_not_empty), .in_entry(q_head), .cfg,
    .out_vld(cv_vld), .out_val(cv_val)
  );

  tvfs_match u_match (
    .clk, .rst, .en, .in_vld(cv_vld), .in_val(cv_val), .cfg,
    .out_valid, .out_item
  );

endmodule
`default_nettype wire

[src/tvfs_front.sv]
`default_nettype none
module tvfs_front import tvfs_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  input  wire cfg_t     cfg,
  input  wire logic     q_full,
  output logic          push,
  output entry_t        entry
);

  logic [55:0]            byte_window;
  logic [OFFSET_BITS-1:0] byte_offset;
  logic [63:0]            full;
  logic [3:0]             size;
  logic [OFFSET_BITS-1:0] size_m1;
  logic [OFFSET_BITS-1:0] start;
  logic [2:0]             align_mask;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign full     = {in_item.data_byte, byte_window};

  always_comb begin
    unique case (cfg.value_kind)
      KIND_F32, KIND_S32, KIND_U32: size = 4'd4;
      KIND_F64, KIND_S64, KIND_U64: size = 4'd8;
      KIND_S8, KIND_U8:             size = 4'd1;
      KIND_S16, KIND_U16:           size = 4'd2;
      default:                      size = 4'd0;
    endcase
  end

  assign size_m1    = OFFSET_BITS'(size - 4'd1);
  assign start      = byte_offset - size_m1;
  assign align_mask = cfg.allow_unaligned ? 3'd0 : size_m1[2:0];

  always_comb begin
    entry.cand  = (size != 4'd0) && (byte_offset >= size_m1) &&
                  ((start[2:0] & align_mask) == 3'd0);
    entry.start = 64'(start);
    entry.last  = in_item.end_of_buffer;
    unique case (size)
      4'd1:    entry.raw = {56'd0, full[63:56]};
      4'd2:    entry.raw = {48'd0, full[63:48]};
      4'd4:    entry.raw = {32'd0, full[63:32]};
      default: entry.raw = full;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_window <= '0;
      byte_offset <= '0;
    end else if (push) begin
      if (in_item.end_of_buffer) begin
        byte_window <= '0;
        byte_offset <= '0;
      end else begin
        byte_window <= full[63:8];
        byte_offset <= byte_offset + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[src/tvfs_queue.sv]
`default_nettype none
module tvfs_queue import tvfs_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  output logic        full,
  input  wire logic   pop,
  output logic        not_empty,
  output entry_t      head
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  entry_t        slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   cnt;
  logic          do_pop;

  assign full      = (cnt == (PW+1)'(QUEUE_DEPTH));
  assign not_empty = (cnt != '0);
  assign head      = slots[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push)   wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      cnt <= cnt + (PW+1)'(push) - (PW+1)'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cnt <= (PW+1)'(QUEUE_DEPTH)) else $error("queue count past depth");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (cnt != (PW+1)'(QUEUE_DEPTH) && cnt != '0) |-> (wr_ptr - rd_ptr) == cnt[PW-1:0])
    else $error("queue pointers disagree with count");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("push into full queue");

endmodule
`default_nettype wire

[src/tvfs_convert.sv]
`default_nettype none
module tvfs_convert import tvfs_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   en,
  input  wire logic   in_vld,
  input  wire entry_t in_entry,
  input  wire cfg_t   cfg,
  output logic        out_vld,
  output val_t        out_val
);

  logic              v1, v2;
  entry_t            e1, e2;
  logic              f64_1, f64_2;
  logic              sign1, sign2;
  logic [63:0]       mag1, mag2;
  logic signed [12:0] eb1, eb2;
  logic [6:0]        lz2;

  logic              c_cand, c_f64, c_sign;
  logic [63:0]       c_mag, c_ext;
  logic signed [12:0] c_eb;

  always_comb begin
    c_cand = in_entry.cand;
    c_f64  = 1'b0;
    c_sign = 1'b0;
    c_mag  = in_entry.raw;
    c_eb   = 13'sd0;
    c_ext  = in_entry.raw;
    unique case (cfg.value_kind)
      KIND_F32: begin
        c_sign = in_entry.raw[31];
        if (in_entry.raw[30:23] == 8'hFF) c_cand = 1'b0;
        if (in_entry.raw[30:23] != 8'd0) begin
          c_mag = {40'd0, 1'b1, in_entry.raw[22:0]};
          c_eb  = $signed({5'd0, in_entry.raw[30:23]}) - 13'sd150;
        end else begin
          c_mag = {41'd0, in_entry.raw[22:0]};
          c_eb  = -13'sd149;
        end
      end
      KIND_F64: begin
        c_f64 = 1'b1;
        if (in_entry.raw[62:52] == 11'h7FF) c_cand = 1'b0;
      end
      KIND_S8, KIND_S16, KIND_S32, KIND_S64: begin
        unique case (cfg.value_kind)
          KIND_S8:  c_ext = {{56{in_entry.raw[7]}}, in_entry.raw[7:0]};
          KIND_S16: c_ext = {{48{in_entry.raw[15]}}, in_entry.raw[15:0]};
          KIND_S32: c_ext = {{32{in_entry.raw[31]}}, in_entry.raw[31:0]};
          default:  c_ext = in_entry.raw;
        endcase
        c_sign = c_ext[63];
        c_mag  = c_ext[63] ? (~c_ext + 64'd1) : c_ext;
      end
      KIND_U8, KIND_U16, KIND_U32, KIND_U64: begin
        c_mag = in_entry.raw;
      end
      default: c_cand = 1'b0;
    endcase
  end

  logic [63:0]        norm;
  logic [52:0]        mant;
  logic               up;
  logic signed [12:0] ex;
  logic [10:0]        ef;
  logic [62:0]        packed_mag;
  logic [63:0]        v3;

  always_comb begin
    norm       = mag2 << lz2;
    mant       = norm[63:11];
    up         = norm[10] && ((|norm[9:0]) || mant[0]);
    ex         = eb2 + 13'sd1086 - $signed({6'd0, lz2});
    ef         = ex[10:0] - 11'd1;
    packed_mag = {ef, 52'd0} + {10'd0, mant} + 63'(up);
    if (f64_2)            v3 = e2.raw;
    else if (mag2 == '0)  v3 = {sign2, 63'd0};
    else                  v3 = {sign2, packed_mag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v1      <= in_vld;
      v2      <= v1;
      out_vld <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1            <= '{cand: c_cand, raw: in_entry.raw, start: in_entry.start,
                         last: in_entry.last};
      f64_1         <= c_f64;
      sign1         <= c_sign;
      mag1          <= c_mag;
      eb1           <= c_eb;
      e2            <= e1;
      f64_2         <= f64_1;
      sign2         <= sign1;
      mag2          <= mag1;
      eb2           <= eb1;
      lz2           <= clz64(mag1);
      out_val.cand  <= e2.cand;
      out_val.v     <= v3;
      out_val.start <= e2.start;
      out_val.last  <= e2.last;
    end
  end

endmodule
`default_nettype wire

[src/tvfs_match.sv]
`default_nettype none
module tvfs_match import tvfs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_vld,
  input  wire val_t in_val,
  input  wire cfg_t cfg,
  output logic      out_valid,
  output out_item_t out_item
);

  logic        v4, v5, v6, v7;
  val_t        p4, p5, p6, p7;
  logic        rok4, rok5, rok6, rok7;
  logic        lnan4, lnan5, lnan6, lnan7;
  logic        linf4, linf5, linf6;
  logic [55:0] abig4, bsh4;
  logic [10:0] ebig4, ebig5;
  logic        sub4;
  logic [56:0] sum5, sum6;
  logic [5:0]  sh6;
  logic [11:0] exe6;
  logic [63:0] dabs7;
  logic [30:0] hit_count;

  logic [63:0]  lo_neg;
  logic [10:0]  ea, eb;
  logic [52:0]  ma, mb;
  logic         a_big;
  logic [10:0]  diff;
  logic [6:0]   diffc;
  logic [111:0] shl;
  logic [10:0]  c_ebig;
  logic [52:0]  c_mbig, c_msml;

  always_comb begin
    lo_neg = {~cfg.target_low_bits[63], cfg.target_low_bits[62:0]};
    ea = (in_val.v[62:52] == 11'd0) ? 11'd1 : in_val.v[62:52];
    eb = (lo_neg[62:52] == 11'd0) ? 11'd1 : lo_neg[62:52];
    ma = {in_val.v[62:52] != 11'd0, in_val.v[51:0]};
    mb = {lo_neg[62:52] != 11'd0, lo_neg[51:0]};
    a_big  = in_val.v[62:0] >= lo_neg[62:0];
    c_ebig = a_big ? ea : eb;
    c_mbig = a_big ? ma : mb;
    c_msml = a_big ? mb : ma;
    diff   = a_big ? (ea - eb) : (eb - ea);
    diffc  = (diff > 11'd56) ? 7'd56 : diff[6:0];
    shl    = {c_msml, 3'd0, 56'd0} >> diffc;
  end

  logic [6:0]  lz;
  logic [6:0]  shc;
  always_comb begin
    lz  = clz64({sum5, 7'h7F});
    shc = ({4'd0, lz} > {1'b0, ebig5}) ? ebig5[6:0] : lz;
  end

  logic [56:0] nrm;
  logic [52:0] mant;
  logic        up;
  logic [62:0] pk;
  logic [63:0] c_dabs;
  always_comb begin
    nrm  = sum6 << sh6;
    mant = nrm[56:4];
    up   = nrm[3] && ((|nrm[2:0]) || mant[0]);
    pk   = {exe6[10:0] - 11'd1, 52'd0} + {10'd0, mant} + 63'(up);
    if (linf6 || exe6 >= 12'd2047) c_dabs = 64'h7FF0_0000_0000_0000;
    else if (sum6 == '0)           c_dabs = 64'd0;
    else                           c_dabs = {1'b0, pk};
  end

  logic match8, hit8;
  logic [30:0] total8;
  always_comb begin
    unique case (cfg.match_mode)
      MODE_EXACT: match8 = !lnan7 && fle(dabs7, cfg.tolerance_bits);
      MODE_RANGE: match8 = rok7;
      default:    match8 = 1'b0;
    endcase
    hit8   = p7.cand && match8 && (hit_count < cfg.hit_limit);
    total8 = hit8 ? (hit_count + 31'd1) : hit_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      out_valid <= 1'b0;
      hit_count <= '0;
    end else if (en) begin
      v4 <= in_vld;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      out_valid <= v7 && (hit8 || p7.last);
      if (v7) hit_count <= p7.last ? 31'd0 : total8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4    <= in_val;
      rok4  <= fle(cfg.target_low_bits, in_val.v) && fle(in_val.v, cfg.target_high_bits);
      lnan4 <= is_nan(cfg.target_low_bits);
      linf4 <= cfg.target_low_bits[62:0] == 63'h7FF0_0000_0000_0000;
      abig4 <= {c_mbig, 3'd0};
      bsh4  <= shl[111:56] | {55'd0, |shl[55:0]};
      ebig4 <= c_ebig;
      sub4  <= in_val.v[63] ^ lo_neg[63];

      p5    <= p4;
      rok5  <= rok4;
      lnan5 <= lnan4;
      linf5 <= linf4;
      ebig5 <= ebig4;
      sum5  <= sub4 ? ({1'b0, abig4} - {1'b0, bsh4}) : ({1'b0, abig4} + {1'b0, bsh4});

      p6    <= p5;
      rok6  <= rok5;
      lnan6 <= lnan5;
      linf6 <= linf5;
      sum6  <= sum5;
      sh6   <= shc[5:0];
      exe6  <= {1'b0, ebig5} + 12'd1 - {5'd0, shc};

      p7    <= p6;
      rok7  <= rok6;
      lnan7 <= lnan6;
      dabs7 <= c_dabs;

      out_item.hit            <= hit8;
      out_item.hit_address    <= hit8 ? (cfg.base_address + p7.start) : 64'd0;
      out_item.hit_value_bits <= hit8 ? p7.v : 64'd0;
      out_item.final_res      <= p7.last;
      out_item.hit_total      <= total8;
    end
  end

  a_hit_counted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.hit) |-> out_item.hit_total != 31'd0)
    else $error("hit reported with zero total");
  a_empty_is_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.hit) |-> out_item.final_res)
    else $error("result without hit that is not final");
  a_count_clears: assert property (@(posedge clk) disable iff (rst)
    (en && v7 && p7.last) |=> hit_count == 31'd0)
    else $error("hit count kept past end of buffer");
  a_limit_kept: assert property (@(posedge clk) disable iff (rst)
    (en && v7 && hit8) |-> hit_count < cfg.hit_limit)
    else $error("hit past limit");

endmodule
`default_nettype wire
